FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, switched off while reset is held.
`define ASSERT_CLK(label, clk_i, rst_ni, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check, also active during reset.
`define ASSERT_ALWAYS(label, clk_i, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// Polyline coordinate decoder package
// Types and constants of the polyline character decoding.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned CoordW = 32;
  localparam int unsigned ChunkW = 5;
  localparam int unsigned CountW = 3;
  localparam int unsigned ShiftW = 6;

  localparam logic [CharW-1:0]  CHAR_OFFSET = 8'd63;
  localparam logic [CharW-1:0]  CHUNK_MASK  = 8'h1f;
  localparam logic [CharW-1:0]  CONT_LOW    = 8'h20;
  localparam logic [CharW-1:0]  CONT_HIGH   = 8'h7f;
  localparam logic [CountW-1:0] LAST_CHUNK  = 3'd7;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [CountW-1:0] count_t;

  // Undo the zig-zag sign folding of a finished number.
  function automatic coord_t unfold(input coord_t a);
    coord_t h;
    h = {a[CoordW-1], a[CoordW-1:1]};
    return a[0] ? ~h : h;
  endfunction

endpackage

FILE: hw/rtl/polyline_coordinate_decoder_core.sv
// ----------------------------------------------------------------------------
// Polyline coordinate decoder core
// Decodes a stream of polyline characters into signed integer coordinates.
// ----------------------------------------------------------------------------
// The core takes one character word per cycle and gives one coordinate word
// for each character that ends a number, latitude and longitude in turn. A
// character passes through an input register and then the decode logic into
// the result register, and the accumulator takes each character as it leaves
// the input register. The input stalls only while the result register holds
// a word that the receiver is stalling.
`include "assert_macros.svh"

module polyline_coordinate_decoder_core
  import pcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CharW-1:0]    in_char_code,
  input  logic                in_first_char,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [CoordW-1:0] out_coord_value,
  output logic                out_is_longitude,
  output logic                out_overflow
);

  logic               s1_valid_r;
  logic [CharW-1:0]   s1_char_r;
  logic               s1_first_r;

  coord_t             acc_r;
  coord_t             acc_nxt;
  count_t             cnt_r;
  count_t             cnt_nxt;
  logic               lon_r;
  logic               lon_nxt;

  logic               out_valid_r;
  coord_t             out_value_r;
  logic               out_lon_r;
  logic               out_ovf_r;

  logic               out_free;
  logic               step;
  logic               res_load;
  logic [CharW-1:0]   v;
  logic               cont;
  coord_t             acc_base;
  count_t             cnt_base;
  logic               lon_base;
  logic [ShiftW-1:0]  shift_amt;
  logic [CoordW+ChunkW-1:0] placed;
  coord_t             acc_or;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign step     = s1_valid_r && out_free;

  always_comb begin
    v         = s1_char_r - CHAR_OFFSET;
    cont      = (v >= CONT_LOW) && (v <= CONT_HIGH);
    acc_base  = s1_first_r ? '0 : acc_r;
    cnt_base  = s1_first_r ? '0 : cnt_r;
    lon_base  = s1_first_r ? 1'b0 : lon_r;
    shift_amt = {1'b0, cnt_base, 2'b00} + {{(ShiftW-CountW){1'b0}}, cnt_base};
    placed    = {{CoordW{1'b0}}, v[ChunkW-1:0] & CHUNK_MASK[ChunkW-1:0]} << shift_amt;
    acc_or    = acc_base | placed[CoordW-1:0];
    res_load  = step && !(cont && (cnt_base != LAST_CHUNK));
    if (!step) begin
      acc_nxt = acc_r;
      cnt_nxt = cnt_r;
      lon_nxt = lon_r;
    end else if (res_load) begin
      acc_nxt = '0;
      cnt_nxt = '0;
      lon_nxt = !lon_base;
    end else begin
      acc_nxt = acc_or;
      cnt_nxt = cnt_base + count_t'(1);
      lon_nxt = lon_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      cnt_r       <= '0;
      lon_r       <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= res_load;
      end
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      lon_r <= lon_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_char_r  <= in_char_code;
      s1_first_r <= in_first_char;
    end
    if (res_load) begin
      out_value_r <= unfold(acc_or);
      out_lon_r   <= lon_base;
      out_ovf_r   <= cont;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coord_value  = out_value_r;
  assign out_is_longitude = out_lon_r;
  assign out_overflow     = out_ovf_r;

  `ASSERT_CLK(a_clear_after_result, clk, rst_n, res_load |=> (acc_r == '0 && cnt_r == '0),
    "accumulator not cleared after a result")
  `ASSERT_CLK(a_pair_toggle, clk, rst_n, (res_load && !s1_first_r) |=> (lon_r != $past(lon_r)),
    "pair toggle did not advance")
  `ASSERT_CLK(a_stall_needs_result, clk, rst_n, in_stall |-> (out_valid_r && s1_valid_r),
    "input stalled without a held result")

endmodule
